@@ rtl/hash_map_key_value_store_assert.svh @@
// ----------------------------------------------------------------------------
// hash map assertion macros
// concurrent checks sampled on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef HASH_MAP_KEY_VALUE_STORE_ASSERT_SVH
`define HASH_MAP_KEY_VALUE_STORE_ASSERT_SVH

// same-cycle implication
`define HMKV_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hash map check failed");

// next-cycle implication
`define HMKV_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hash map check failed");

`endif

@@ rtl/hmkv_pkg.sv @@
// ----------------------------------------------------------------------------
// hmkv_pkg
// types and constants of the set-associative key-value table
// ----------------------------------------------------------------------------
`default_nettype none

package hmkv_pkg;

    // table geometry, bucket count is a power of two
    localparam int BUCKETS = 1024;
    localparam int WAYS    = 4;
    localparam int BKT_W   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;

    // field widths
    localparam int OP_W  = 2;
    localparam int KEY_W = 20;
    localparam int VAL_W = 20;
    localparam int ST_W  = 2;
    localparam int RV_W  = 21;

    // operation codes
    localparam logic [OP_W-1:0] OP_PUT    = 2'd0;
    localparam logic [OP_W-1:0] OP_GET    = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    // status codes
    localparam logic [ST_W-1:0] ST_OK   = 2'd0;
    localparam logic [ST_W-1:0] ST_MISS = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL = 2'd2;

    // read value when no value is returned
    localparam logic signed [RV_W-1:0] RV_NONE = '1;

    // one slot and one bucket row
    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } slot_t;

    typedef slot_t [WAYS-1:0] row_t;

endpackage

`default_nettype wire

@@ rtl/hash_map_key_value_store.sv @@
// A taken request reads its bucket row into a register; in the lookup state the
// result is loaded into the output register once that register is free or not
// stalled. No new request is taken before then: req_stall stays high while the
// row is read, modified and written back. Reset: a clearing pass over all BUCKETS
// rows (1024) writes every row invalid; req_stall stays high until it finishes.
// ----------------------------------------------------------------------------
// hash_map_key_value_store
// set-associative key-value table with put, get and remove requests
// ----------------------------------------------------------------------------
`default_nettype none

`include "hash_map_key_value_store_assert.svh"

module hash_map_key_value_store (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               req_valid,
    output logic                                    req_stall,
    input  wire logic [hmkv_pkg::OP_W-1:0]          operation,
    input  wire logic [hmkv_pkg::KEY_W-1:0]         lookup_key,
    input  wire logic [hmkv_pkg::VAL_W-1:0]         store_value,
    output logic                                    rsp_valid,
    input  wire logic                               rsp_stall,
    output logic [hmkv_pkg::ST_W-1:0]               status,
    output logic signed [hmkv_pkg::RV_W-1:0]        read_value
);
    import hmkv_pkg::*;

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_LOOK  = 2'd2;

    logic [1:0]             state_reg, state_next;
    logic [BKT_W-1:0]       clr_cnt_reg, clr_cnt_next;
    logic [OP_W-1:0]        op_reg;
    logic [KEY_W-1:0]       key_reg;
    logic [VAL_W-1:0]       val_reg;
    row_t                   rd_row_reg;
    row_t                   row_mem [BUCKETS];
    logic                   rsp_valid_reg, rsp_valid_next;
    logic [ST_W-1:0]        status_reg;
    logic signed [RV_W-1:0] read_value_reg;

    logic                   accept;
    logic                   load;
    logic                   mem_we;
    logic [BKT_W-1:0]       mem_waddr;
    row_t                   mem_wdata;

    logic [WAYS-1:0]        hit_vec;
    logic                   hit_any;
    logic [WAY_W-1:0]       hit_idx;
    logic                   free_any;
    logic [WAY_W-1:0]       free_idx;
    row_t                   new_row;
    logic                   row_dirty;
    logic [ST_W-1:0]        st_calc;
    logic signed [RV_W-1:0] rv_calc;

    // handshake
    assign req_stall = (state_reg != S_IDLE);
    assign accept    = req_valid && (state_reg == S_IDLE);
    assign load      = (state_reg == S_LOOK) && (!rsp_valid_reg || !rsp_stall);

    // row memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            row_mem[mem_waddr] <= mem_wdata;
        end
        if (accept)
        begin
            rd_row_reg <= row_mem[lookup_key[BKT_W-1:0]];
        end
    end

    // way match and free slot search, lowest way wins
    always_comb
    begin
        hit_vec  = '0;
        hit_any  = 1'b0;
        hit_idx  = '0;
        free_any = 1'b0;
        free_idx = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            hit_vec[w] = rd_row_reg[w].valid && (rd_row_reg[w].key == key_reg);
            if (hit_vec[w])
            begin
                hit_any = 1'b1;
                hit_idx = WAY_W'(w);
            end
            if (!rd_row_reg[w].valid)
            begin
                free_any = 1'b1;
                free_idx = WAY_W'(w);
            end
        end
    end

    // modify the row and form the result
    always_comb
    begin
        new_row   = rd_row_reg;
        row_dirty = 1'b0;
        st_calc   = ST_OK;
        rv_calc   = RV_NONE;
        case (op_reg)
            OP_PUT:
            begin
                if (hit_any)
                begin
                    new_row[hit_idx].value = val_reg;
                    row_dirty = 1'b1;
                end
                else if (free_any)
                begin
                    new_row[free_idx].valid = 1'b1;
                    new_row[free_idx].key   = key_reg;
                    new_row[free_idx].value = val_reg;
                    row_dirty = 1'b1;
                end
                else
                begin
                    st_calc = ST_FULL;
                end
            end
            OP_GET:
            begin
                if (hit_any)
                begin
                    rv_calc = $signed({1'b0, rd_row_reg[hit_idx].value});
                end
                else
                begin
                    st_calc = ST_MISS;
                end
            end
            OP_REMOVE:
            begin
                if (hit_any)
                begin
                    new_row[hit_idx].valid = 1'b0;
                    row_dirty = 1'b1;
                end
                else
                begin
                    st_calc = ST_MISS;
                end
            end
            default:
            begin
                st_calc = ST_OK;
            end
        endcase
    end

    // memory write port: clearing pass or write-back
    always_comb
    begin
        if (state_reg == S_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = load && row_dirty;
            mem_waddr = key_reg[BKT_W-1:0];
            mem_wdata = new_row;
        end
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        case (state_reg)
            S_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == BKT_W'(BUCKETS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                if (load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // output register
    always_comb
    begin
        if (load)
        begin
            rsp_valid_next = 1'b1;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg && rsp_stall;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= operation;
            key_reg <= lookup_key;
            val_reg <= store_value;
        end
        if (load)
        begin
            status_reg     <= st_calc;
            read_value_reg <= rv_calc;
        end
    end

    assign rsp_valid  = rsp_valid_reg;
    assign status     = status_reg;
    assign read_value = read_value_reg;

    // checks
    `HMKV_ASSERT_NOW(a_no_accept_in_clear, state_reg == S_CLEAR, req_stall)
    `HMKV_ASSERT_NEXT(a_load_gives_word, load, rsp_valid_reg)
    `HMKV_ASSERT_NOW(a_write_source, mem_we, (state_reg == S_CLEAR) || load)
    `HMKV_ASSERT_NOW(a_value_only_on_hit, rsp_valid_reg && (read_value_reg != RV_NONE),
        status_reg == ST_OK)

endmodule

`default_nettype wire
